// File: sv/bmp_blit_pkg.sv
`timescale 1ns / 1ps

package bmp_blit_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_FB_WIDTH   = 3'd0;
	localparam logic [2:0] REG_FB_HEIGHT  = 3'd1;
	localparam logic [2:0] REG_FB_STRIDE  = 3'd2;
	localparam logic [2:0] REG_FB_DEPTH   = 3'd3;
	localparam logic [2:0] REG_IMG_WIDTH  = 3'd4;
	localparam logic [2:0] REG_IMG_HEIGHT = 3'd5;
	localparam logic [2:0] REG_IMG_DEPTH  = 3'd6;
	localparam logic [2:0] REG_IMG_BOTUP  = 3'd7;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_DEPTH = 2'd1;
	localparam logic [1:0] ST_SIZE  = 2'd2;

	localparam logic [5:0]  DEPTH_24    = 6'd24;
	localparam logic [5:0]  DEPTH_32    = 6'd32;
	localparam logic [31:0] ARGB_OPAQUE = 32'hFF00_0000;

	typedef struct packed {
		logic [12:0] fb_width;
		logic [12:0] fb_height;
		logic [15:0] fb_stride;
		logic [5:0]  fb_depth;
		logic [12:0] img_width;
		logic [12:0] img_height;
		logic [5:0]  img_depth;
		logic        img_bottom_up;
	} cfg_t;

	// per-byte decision handed from the row tracker to the address stages
	typedef struct packed {
		logic        wv;
		logic        wide;
		logic [31:0] data;
		logic [16:0] off;
		logic [12:0] drow;
		logic [1:0]  st;
		logic        done;
	} trk_t;

endpackage

// File: sv/bmp_blit_track.sv
`timescale 1ns / 1ps

module bmp_blit_track import bmp_blit_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  cfg_t       cfg,
	input  logic       fs,
	input  logic [7:0] b,
	output trk_t       trk_s2
);

	logic [15:0] bir_q;
	logic [12:0] rc_q;
	logic [15:0] held_q;
	logic        fin_q;
	logic [1:0]  ph_q;
	logic [16:0] pxo_q;

	logic [15:0] pos, bir_d;
	logic [12:0] rc, rc_d, rc_inc;
	logic [15:0] held, held_d;
	logic        fin, fin_d;
	logic [1:0]  ph, ph_d;
	logic [16:0] pxo, pxo_d;
	logic        depth_ok, too_big, active, is32, same, conv, row_end;
	logic [14:0] cp, sstride;
	logic [17:0] bits24;
	trk_t        trk;

	always_comb begin
		// frame start clears the counters before this byte
		pos  = fs ? '0 : bir_q;
		rc   = fs ? '0 : rc_q;
		held = fs ? '0 : held_q;
		fin  = fs ? 1'b0 : fin_q;
		ph   = fs ? '0 : ph_q;
		pxo  = fs ? '0 : pxo_q;

		depth_ok = (cfg.img_depth == DEPTH_24) || (cfg.img_depth == DEPTH_32);
		too_big  = (cfg.img_width > cfg.fb_width) || (cfg.img_height > cfg.fb_height);
		active   = (cfg.img_width != '0) && (cfg.img_height != '0) && !fin
			&& (rc < cfg.img_height);
		is32     = cfg.img_depth == DEPTH_32;
		same     = cfg.fb_depth == cfg.img_depth;
		conv     = (cfg.img_depth == DEPTH_24) && (cfg.fb_depth == DEPTH_32);

		cp = is32 ? {cfg.img_width, 2'b00}
			: ({1'b0, cfg.img_width, 1'b0} + {2'b00, cfg.img_width});
		bits24 = {1'b0, cfg.img_width, 4'b0000} + {2'b00, cfg.img_width, 3'b000} + 18'd31;
		sstride = is32 ? {cfg.img_width, 2'b00} : {bits24[17:5], 2'b00};
		row_end = ({1'b0, pos} + 17'd1) >= {2'b00, sstride};
		rc_inc  = rc + 13'd1;

		bir_d  = pos;
		rc_d   = rc;
		held_d = held;
		fin_d  = fin;
		ph_d   = ph;
		pxo_d  = pxo;

		trk      = '0;
		trk.drow = cfg.img_bottom_up ? (cfg.img_height - 13'd1 - rc) : rc;

		if (!depth_ok) begin
			trk.st = ST_DEPTH;
		end else if (too_big) begin
			trk.st = ST_SIZE;
		end else if (active) begin
			trk.st = ST_OK;
			if (pos < {1'b0, cp}) begin
				if (same) begin
					trk.wv   = 1'b1;
					trk.off  = {1'b0, pos};
					trk.data = {24'd0, b};
				end else if (conv) begin
					case (ph)
						2'd0: held_d = {held[15:8], b};
						2'd1: held_d = {b, held[7:0]};
						default: begin
							trk.wv   = 1'b1;
							trk.wide = 1'b1;
							trk.off  = pxo;
							trk.data = ARGB_OPAQUE | {8'd0, b, held};
						end
					endcase
				end
			end
			if (row_end) begin
				bir_d = '0;
				ph_d  = '0;
				pxo_d = '0;
				rc_d  = rc_inc;
				if (rc_inc >= cfg.img_height) begin
					fin_d    = 1'b1;
					trk.done = 1'b1;
				end
			end else begin
				bir_d = pos + 16'd1;
				// phase and pixel offset track pos mod 3 and (pos / 3) * 4
				if (ph == 2'd2) begin
					ph_d  = '0;
					pxo_d = pxo + 17'd4;
				end else begin
					ph_d = ph + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bir_q  <= '0;
			rc_q   <= '0;
			held_q <= '0;
			fin_q  <= 1'b0;
			ph_q   <= '0;
			pxo_q  <= '0;
		end else if (adv) begin
			bir_q  <= bir_d;
			rc_q   <= rc_d;
			held_q <= held_d;
			fin_q  <= fin_d;
			ph_q   <= ph_d;
			pxo_q  <= pxo_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			trk_s2 <= trk;
		end
	end

endmodule

// File: sv/bmp_blit_addr.sv
`timescale 1ns / 1ps

module bmp_blit_addr import bmp_blit_pkg::*; #(
	parameter int ADDR_BITS = 32
) (
	input  logic        clk,
	input  logic        en3,
	input  logic        en_out,
	input  cfg_t        cfg,
	input  trk_t        trk_s2,
	output logic        write_valid,
	output logic [31:0] write_addr,
	output logic [31:0] write_data,
	output logic        write_wide,
	output logic [1:0]  status,
	output logic        image_done
);

	logic [12:0] dh, dw;
	logic [13:0] row_idx;
	logic [29:0] prod;
	logic [17:0] lx;

	logic [29:0] prod_s3;
	logic [14:0] lterm_s3;
	trk_t        trk_s3;

	logic [31:0] sum, addr_w;

	always_comb begin
		dh      = cfg.fb_height - cfg.img_height;
		dw      = cfg.fb_width - cfg.img_width;
		row_idx = {2'b00, dh[12:1]} + {1'b0, trk_s2.drow};
		prod    = {14'd0, cfg.fb_stride} * {16'd0, row_idx};
		lx      = {6'd0, dw[12:1]} * {12'd0, cfg.fb_depth};
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			prod_s3  <= prod;
			lterm_s3 <= lx[17:3];
			trk_s3   <= trk_s2;
		end
	end

	always_comb begin
		sum = {2'b00, prod_s3} + {17'd0, lterm_s3} + {15'd0, trk_s3.off};
		// wrap to the address space
		for (int i = 0; i < 32; i++) begin
			addr_w[i] = (i < ADDR_BITS) ? sum[i] : 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			write_valid <= trk_s3.wv;
			write_addr  <= trk_s3.wv ? addr_w : '0;
			write_data  <= trk_s3.wv ? trk_s3.data : '0;
			write_wide  <= trk_s3.wv & trk_s3.wide;
			status      <= trk_s3.st;
			image_done  <= trk_s3.done;
		end
	end

endmodule

// File: sv/bmp_to_framebuffer_blit.sv
`timescale 1ns / 1ps

// BMP pixel-data to framebuffer blitter. Pixel-data bytes arrive in file order, one per
// transaction, and each produces one result transaction carrying at most one framebuffer
// write (byte write, or ARGB word write for a 24-bit image on a 32-bit framebuffer).
// The image is centered, bottom-up images are flipped and row padding is skipped.
// One byte is accepted every clock while out_ready takes the results; each result passes
// the input register, row/byte tracker, stride multiplier, address add and output register.
// The tracker's counters update as each byte advances, so consecutive bytes never wait on
// each other. Write the configuration only while the block holds no bytes in flight.
module bmp_to_framebuffer_blit import bmp_blit_pkg::*; #(
	parameter int ADDR_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        frame_start,
	input  logic [7:0]  pix_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        write_valid,
	output logic [31:0] write_addr,
	output logic [31:0] write_data,
	output logic        write_wide,
	output logic [1:0]  status,
	output logic        image_done
);

	cfg_t       cfg_q;
	logic       v_s1, v_s2, v_s3, vo_q;
	logic       fs_s1;
	logic [7:0] b_s1;
	logic       rdy_o, rdy3, rdy2;
	logic       adv1, adv2, adv3;
	trk_t       trk_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fb_width      <= 13'd1920;
			cfg_q.fb_height     <= 13'd1080;
			cfg_q.fb_stride     <= 16'd7680;
			cfg_q.fb_depth      <= 6'd32;
			cfg_q.img_width     <= 13'd1;
			cfg_q.img_height    <= 13'd1;
			cfg_q.img_depth     <= 6'd24;
			cfg_q.img_bottom_up <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_FB_WIDTH:   cfg_q.fb_width      <= cfg_data[12:0];
				REG_FB_HEIGHT:  cfg_q.fb_height     <= cfg_data[12:0];
				REG_FB_STRIDE:  cfg_q.fb_stride     <= cfg_data;
				REG_FB_DEPTH:   cfg_q.fb_depth      <= cfg_data[5:0];
				REG_IMG_WIDTH:  cfg_q.img_width     <= cfg_data[12:0];
				REG_IMG_HEIGHT: cfg_q.img_height    <= cfg_data[12:0];
				REG_IMG_DEPTH:  cfg_q.img_depth     <= cfg_data[5:0];
				REG_IMG_BOTUP:  cfg_q.img_bottom_up <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// each stage moves on when the next one is empty or moving
	assign rdy_o    = !vo_q || out_ready;
	assign rdy3     = !v_s3 || rdy_o;
	assign rdy2     = !v_s2 || rdy3;
	assign in_ready = !v_s1 || rdy2;
	assign adv1     = v_s1 && rdy2;
	assign adv2     = v_s2 && rdy3;
	assign adv3     = v_s3 && rdy_o;
	assign out_valid = vo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (in_ready) v_s1 <= in_valid;
			if (rdy2)     v_s2 <= v_s1;
			if (rdy3)     v_s3 <= v_s2;
			if (rdy_o)    vo_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			fs_s1 <= frame_start;
			b_s1  <= pix_byte;
		end
	end

	bmp_blit_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv1),
		.cfg    (cfg_q),
		.fs     (fs_s1),
		.b      (b_s1),
		.trk_s2 (trk_s2)
	);

	bmp_blit_addr #(
		.ADDR_BITS (ADDR_BITS)
	) u_addr (
		.clk         (clk),
		.en3         (adv2),
		.en_out      (adv3),
		.cfg         (cfg_q),
		.trk_s2      (trk_s2),
		.write_valid (write_valid),
		.write_addr  (write_addr),
		.write_data  (write_data),
		.write_wide  (write_wide),
		.status      (status),
		.image_done  (image_done)
	);

endmodule

// File: verif/tb_bmp_to_framebuffer_blit.sv
`timescale 1ns / 1ps

module tb_bmp_to_framebuffer_blit;
	import bmp_blit_pkg::*;

	localparam int ITEMS          = 1250;
	localparam int RX_HOLD_CYCLES = 150;
	localparam int NDIR           = 36;

	typedef struct packed {
		logic        wv;
		logic [31:0] addr;
		logic [31:0] data;
		logic        wide;
		logic [1:0]  st;
		logic        done;
	} blit_res_t;

	typedef enum logic [1:0] {ROW_BYTE, ROW_CHECK, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [2:0]  idx;
		logic [15:0] val;
		logic        fs;
		logic [7:0]  pix;
		blit_res_t   want;
	} dir_row_t;

	localparam blit_res_t RES_IDLE  = '0;
	localparam blit_res_t RES_DEPTH = '{1'b0, 32'd0, 32'd0, 1'b0, ST_DEPTH, 1'b0};
	localparam blit_res_t RES_SIZE  = '{1'b0, 32'd0, 32'd0, 1'b0, ST_SIZE, 1'b0};

	// ROW_CHECK rows carry a typed expectation, ROW_BYTE rows go through the predictor
	localparam dir_row_t DIR_TAB [NDIR] = '{
		'{ROW_BYTE,  REG_FB_WIDTH,   16'd0,     1'b1, 8'h11, RES_IDLE},
		'{ROW_BYTE,  REG_FB_WIDTH,   16'd0,     1'b0, 8'h22, RES_IDLE},
		'{ROW_BYTE,  REG_FB_WIDTH,   16'd0,     1'b0, 8'h33, RES_IDLE},
		'{ROW_BYTE,  REG_FB_WIDTH,   16'd0,     1'b0, 8'hFF, RES_IDLE},
		// byte after the last row is ignored
		'{ROW_CHECK, REG_FB_WIDTH,   16'd0,     1'b0, 8'h00, RES_IDLE},
		'{ROW_CFG,   REG_IMG_DEPTH,  16'd0,     1'b0, 8'h00, RES_IDLE},
		'{ROW_CHECK, REG_FB_WIDTH,   16'd0,     1'b0, 8'hAA, RES_DEPTH},
		'{ROW_CFG,   REG_IMG_DEPTH,  16'd32,    1'b0, 8'h00, RES_IDLE},
		'{ROW_CFG,   REG_IMG_WIDTH,  16'd8191,  1'b0, 8'h00, RES_IDLE},
		'{ROW_CHECK, REG_FB_WIDTH,   16'd0,     1'b1, 8'h55, RES_SIZE},
		'{ROW_CFG,   REG_IMG_WIDTH,  16'd1,     1'b0, 8'h00, RES_IDLE},
		'{ROW_CFG,   REG_IMG_HEIGHT, 16'd8191,  1'b0, 8'h00, RES_IDLE},
		'{ROW_CHECK, REG_FB_WIDTH,   16'd0,     1'b0, 8'h5A, RES_SIZE},
		'{ROW_CFG,   REG_FB_WIDTH,   16'd8191,  1'b0, 8'h00, RES_IDLE},
		'{ROW_CFG,   REG_FB_HEIGHT,  16'd8191,  1'b0, 8'h00, RES_IDLE},
		'{ROW_CFG,   REG_IMG_WIDTH,  16'd8191,  1'b0, 8'h00, RES_IDLE},
		'{ROW_BYTE,  REG_FB_WIDTH,   16'd0,     1'b1, 8'h00, RES_IDLE},
		'{ROW_BYTE,  REG_FB_WIDTH,   16'd0,     1'b0, 8'hFF, RES_IDLE},
		'{ROW_BYTE,  REG_FB_WIDTH,   16'd0,     1'b0, 8'h80, RES_IDLE},
		'{ROW_CFG,   REG_FB_STRIDE,  16'hFFFF,  1'b0, 8'h00, RES_IDLE},
		'{ROW_CFG,   REG_IMG_BOTUP,  16'd0,     1'b0, 8'h00, RES_IDLE},
		// continues mid-row under the new stride and orientation
		'{ROW_BYTE,  REG_FB_WIDTH,   16'd0,     1'b0, 8'h7F, RES_IDLE},
		'{ROW_BYTE,  REG_FB_WIDTH,   16'd0,     1'b1, 8'h01, RES_IDLE},
		'{ROW_CFG,   REG_IMG_WIDTH,  16'd0,     1'b0, 8'h00, RES_IDLE},
		// empty image
		'{ROW_CHECK, REG_FB_WIDTH,   16'd0,     1'b1, 8'h12, RES_IDLE},
		'{ROW_CFG,   REG_FB_DEPTH,   16'd0,     1'b0, 8'h00, RES_IDLE},
		'{ROW_CFG,   REG_IMG_WIDTH,  16'd2,     1'b0, 8'h00, RES_IDLE},
		'{ROW_CFG,   REG_IMG_HEIGHT, 16'd1,     1'b0, 8'h00, RES_IDLE},
		// depth pairing with no writes, still counts rows
		'{ROW_BYTE,  REG_FB_WIDTH,   16'd0,     1'b1, 8'hC3, RES_IDLE},
		'{ROW_BYTE,  REG_FB_WIDTH,   16'd0,     1'b0, 8'h3C, RES_IDLE},
		'{ROW_BYTE,  REG_FB_WIDTH,   16'd0,     1'b0, 8'h96, RES_IDLE},
		'{ROW_BYTE,  REG_FB_WIDTH,   16'd0,     1'b0, 8'h69, RES_IDLE},
		'{ROW_BYTE,  REG_FB_WIDTH,   16'd0,     1'b0, 8'hA5, RES_IDLE},
		'{ROW_BYTE,  REG_FB_WIDTH,   16'd0,     1'b0, 8'h5A, RES_IDLE},
		'{ROW_BYTE,  REG_FB_WIDTH,   16'd0,     1'b0, 8'hF0, RES_IDLE},
		'{ROW_BYTE,  REG_FB_WIDTH,   16'd0,     1'b0, 8'h0F, RES_IDLE}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_idx;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic        frame_start;
	logic [7:0]  pix_byte;
	logic        out_valid;
	logic        out_ready;
	logic        write_valid;
	logic [31:0] write_addr;
	logic [31:0] write_data;
	logic        write_wide;
	logic [1:0]  status;
	logic        image_done;

	bmp_to_framebuffer_blit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.frame_start (frame_start),
		.pix_byte    (pix_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.write_valid (write_valid),
		.write_addr  (write_addr),
		.write_data  (write_data),
		.write_wide  (write_wide),
		.status      (status),
		.image_done  (image_done)
	);

	always #5 clk = ~clk;

	// register shadow and blit tracker state
	cfg_t regs = '{fb_width: 13'd1920, fb_height: 13'd1080, fb_stride: 16'd7680,
		fb_depth: DEPTH_32, img_width: 13'd1, img_height: 13'd1, img_depth: DEPTH_24,
		img_bottom_up: 1'b1};
	logic [15:0] col_pos      = '0;
	logic [12:0] rows_done    = '0;
	logic [15:0] held_bg      = '0;
	logic        img_finished = 1'b0;
	bit          last_took;

	blit_res_t   write_q [$];

	bit          tx_idle = 1'b1;
	bit          rx_idle = 1'b1;
	bit          rx_hold = 1'b0;
	bit          held_once = 1'b0;

	int unsigned fail_cnt, sent_cnt, taken_cnt, phase_cnt, hold_cnt;
	int unsigned byte_wr_cnt, word_wr_cnt, done_cnt, err_cnt;

	function automatic blit_res_t blit_predict(input logic fs, input logic [7:0] b);
		blit_res_t r;
		longint unsigned iw, ih, idep, fdep, fst, cp, sstride, left, top, drow, base, pos, a;
		r = '0;
		last_took = 1'b0;
		if (fs) begin
			col_pos = '0;
			rows_done = '0;
			held_bg = '0;
			img_finished = 1'b0;
		end
		iw = regs.img_width;
		ih = regs.img_height;
		idep = regs.img_depth;
		fdep = regs.fb_depth;
		fst = regs.fb_stride;
		if (regs.img_depth != DEPTH_24 && regs.img_depth != DEPTH_32) begin
			r.st = ST_DEPTH;
			last_took = 1'b1;
		end else if (regs.img_width > regs.fb_width || regs.img_height > regs.fb_height) begin
			r.st = ST_SIZE;
			last_took = 1'b1;
		end else if (iw != 0 && ih != 0 && !img_finished && rows_done < regs.img_height) begin
			last_took = 1'b1;
			cp = (iw * idep) >> 3;
			sstride = ((iw * idep + 31) >> 5) << 2;
			left = (longint'(regs.fb_width) - iw) >> 1;
			top = (longint'(regs.fb_height) - ih) >> 1;
			drow = regs.img_bottom_up ? ih - 1 - rows_done : rows_done;
			base = fst * (top + drow) + ((left * fdep) >> 3);
			pos = col_pos;
			if (pos < cp) begin
				if (regs.fb_depth == regs.img_depth) begin
					a = base + pos;
					r.wv = 1'b1;
					r.addr = a[31:0];
					r.data = {24'd0, b};
				end else if (regs.img_depth == DEPTH_24 && regs.fb_depth == DEPTH_32) begin
					case (pos % 3)
						0: held_bg[7:0] = b;
						1: held_bg[15:8] = b;
						default: begin
							a = base + (pos / 3) * 4;
							r.wv = 1'b1;
							r.wide = 1'b1;
							r.addr = a[31:0];
							r.data = ARGB_OPAQUE | {8'd0, b, held_bg};
						end
					endcase
				end
			end
			if (pos + 1 >= sstride) begin
				col_pos = '0;
				rows_done = rows_done + 13'd1;
				if (rows_done >= regs.img_height) begin
					img_finished = 1'b1;
					r.done = 1'b1;
				end
			end else begin
				a = pos + 1;
				col_pos = a[15:0];
			end
		end
		return r;
	endfunction

	function automatic void note_failure(input string what, input blit_res_t got,
		input blit_res_t want);
		fail_cnt++;
		if (fail_cnt <= 10)
			$display("%0t %s: got wv=%0b addr=%h data=%h wide=%0b st=%0d done=%0b, expected wv=%0b addr=%h data=%h wide=%0b st=%0d done=%0b",
				$time, what, got.wv, got.addr, got.data, got.wide, got.st, got.done,
				want.wv, want.addr, want.data, want.wide, want.st, want.done);
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		case (idx)
			REG_FB_WIDTH:   regs.fb_width = val[12:0];
			REG_FB_HEIGHT:  regs.fb_height = val[12:0];
			REG_FB_STRIDE:  regs.fb_stride = val;
			REG_FB_DEPTH:   regs.fb_depth = val[5:0];
			REG_IMG_WIDTH:  regs.img_width = val[12:0];
			REG_IMG_HEIGHT: regs.img_height = val[12:0];
			REG_IMG_DEPTH:  regs.img_depth = val[5:0];
			default:        regs.img_bottom_up = val[0];
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// stop offering bytes, let every pending result come back, then let the pipe settle
	task automatic drain_and_settle();
		in_valid <= 1'b0;
		while (write_q.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic send_byte(input logic fs, input logic [7:0] b, input bit typed,
		input blit_res_t want);
		int gap;
		blit_res_t pred;
		gap = tx_idle ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		frame_start <= fs;
		pix_byte <= b;
		do @(posedge clk); while (!in_ready);
		pred = blit_predict(fs, b);
		write_q.push_back(typed ? want : pred);
		sent_cnt++;
		if (last_took)
			taken_cnt++;
	endtask

	function automatic int pick_dim(input int usual);
		case ($urandom_range(0, 19))
			0: return 0;
			1: return $urandom_range(1, 8191);
			2: return 8191;
			default: return $urandom_range(1, usual);
		endcase
	endfunction

	function automatic int pick_span(input int img);
		int v;
		case ($urandom_range(0, 9))
			0: v = 8191;
			1: v = $urandom_range(1, 8191);
			2: v = img;
			3: v = 1;
			default: v = img + $urandom_range(0, 40);
		endcase
		if (v < 1)
			v = 1;
		if (v > 8191)
			v = 8191;
		return v;
	endfunction

	function automatic logic [5:0] pick_depth(input int odd_pct);
		logic [31:0] r;
		r = $urandom;
		if ($urandom_range(0, 99) < odd_pct)
			return r[5:0];
		return r[6] ? DEPTH_32 : DEPTH_24;
	endfunction

	task automatic run_phase();
		int iw, ih, fw, fh, stv, frames;
		longint unsigned w, d, total, k;
		logic [31:0] rnd;
		bit keep, fs;
		drain_and_settle();
		iw = pick_dim(6);
		ih = pick_dim(5);
		fw = pick_span(iw);
		fh = pick_span(ih);
		case ($urandom_range(0, 9))
			0: stv = 65535;
			1: stv = 1;
			2, 3: stv = $urandom_range(1, 65535);
			default: stv = (fw * 4 > 65535) ? 65535 : fw * 4;
		endcase
		write_reg(REG_FB_WIDTH, 16'(fw));
		write_reg(REG_FB_HEIGHT, 16'(fh));
		write_reg(REG_FB_STRIDE, 16'(stv));
		write_reg(REG_FB_DEPTH, {10'd0, pick_depth(30)});
		write_reg(REG_IMG_WIDTH, 16'(iw));
		write_reg(REG_IMG_HEIGHT, 16'(ih));
		write_reg(REG_IMG_DEPTH, {10'd0, pick_depth(20)});
		rnd = $urandom;
		write_reg(REG_IMG_BOTUP, {15'd0, rnd[0]});
		phase_cnt++;
		tx_idle = ($urandom_range(0, 3) != 0);
		rx_idle = ($urandom_range(0, 3) != 0);
		// sometimes carry the old counters into the new setting
		keep = ($urandom_range(0, 5) == 0);
		frames = $urandom_range(1, 2);
		for (int f = 0; f < frames; f++) begin
			if ((regs.img_depth == DEPTH_24 || regs.img_depth == DEPTH_32) &&
				regs.img_width <= regs.fb_width && regs.img_height <= regs.fb_height &&
				regs.img_width != 0 && regs.img_height != 0) begin
				w = regs.img_width;
				d = regs.img_depth;
				total = (((w * d + 31) >> 5) << 2) * regs.img_height;
			end else begin
				total = $urandom_range(3, 12);
			end
			if (total > 240)
				total = $urandom_range(4, 40);
			else if ($urandom_range(0, 7) == 0)
				total = $urandom_range(1, int'(total));
			else if ($urandom_range(0, 3) == 0)
				total = total + $urandom_range(1, 3);
			if (total >= 30 && (!held_once || $urandom_range(0, 11) == 0)) begin
				// receiver stops for a long stretch while bytes keep coming
				held_once = 1'b1;
				tx_idle = 1'b0;
				rx_hold = 1'b1;
			end
			for (k = 0; k < total; k++) begin
				rnd = $urandom;
				fs = (k == 0 && !(keep && f == 0)) || ($urandom_range(0, 99) == 0);
				send_byte(fs, rnd[7:0], 1'b0, RES_IDLE);
			end
		end
	endtask

	// result side
	initial begin
		int stall;
		blit_res_t got, want;
		string bad;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (rx_hold) begin
				out_ready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				rx_hold = 1'b0;
				hold_cnt++;
			end
			stall = rx_idle ? $urandom_range(0, 10) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			got = '{write_valid, write_addr, write_data, write_wide, status, image_done};
			if (write_q.size() == 0) begin
				note_failure("result transaction with nothing pending", got, RES_IDLE);
			end else begin
				want = write_q.pop_front();
				bad = "";
				if (got.wv !== want.wv)     bad = {bad, " write_valid"};
				if (got.addr !== want.addr) bad = {bad, " write_addr"};
				if (got.data !== want.data) bad = {bad, " write_data"};
				if (got.wide !== want.wide) bad = {bad, " write_wide"};
				if (got.st !== want.st)     bad = {bad, " status"};
				if (got.done !== want.done) bad = {bad, " image_done"};
				if (bad != "")
					note_failure({"mismatch on", bad}, got, want);
				if (want.wv && want.wide)
					word_wr_cnt++;
				else if (want.wv)
					byte_wr_cnt++;
				if (want.done)
					done_cnt++;
				if (want.st != ST_OK)
					err_cnt++;
			end
		end
	end

	// stimulus side
	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= REG_FB_WIDTH;
		cfg_data <= '0;
		in_valid <= 1'b0;
		frame_start <= 1'b0;
		pix_byte <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < NDIR; i++) begin
			case (DIR_TAB[i].kind)
				ROW_CFG: begin
					drain_and_settle();
					write_reg(DIR_TAB[i].idx, DIR_TAB[i].val);
				end
				ROW_CHECK: send_byte(DIR_TAB[i].fs, DIR_TAB[i].pix, 1'b1, DIR_TAB[i].want);
				default:   send_byte(DIR_TAB[i].fs, DIR_TAB[i].pix, 1'b0, RES_IDLE);
			endcase
		end
		while (taken_cnt < ITEMS)
			run_phase();
		drain_and_settle();
		repeat (4) @(posedge clk);
		$display("covered %0d bytes (%0d taken) over %0d register settings, %0d long output stalls",
			sent_cnt, taken_cnt, phase_cnt, hold_cnt);
		$display("saw %0d byte writes, %0d word writes, %0d finished images, %0d error results",
			byte_wr_cnt, word_wr_cnt, done_cnt, err_cnt);
		if (fail_cnt == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("timeout with %0d results still pending", write_q.size());
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: bmp_to_framebuffer_blit.f
sv/bmp_blit_pkg.sv
sv/bmp_blit_track.sv
sv/bmp_blit_addr.sv
sv/bmp_to_framebuffer_blit.sv
verif/tb_bmp_to_framebuffer_blit.sv
